[hdl/wpim_pkg.sv]
`default_nettype none

package wpim_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int PATTERN_MAX_DEF   = 32;
    localparam int ALPHABET_SIZE_DEF = 26;

    // Fixed field widths.
    localparam int LETTER_W   = 5;
    localparam int PLEN_W     = 6;
    localparam int LETTERS0_W = 60;
    localparam int LETTERS1_W = 60;
    localparam int LETTERS2_W = 40;
    localparam int PAT_BITS   = LETTERS0_W + LETTERS1_W + LETTERS2_W;

    // Register interface.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 64;
    localparam int REG_IDX_W  = 2;

    // Register indexes, taken from paddr[4:3].
    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LETTERS_0      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_LETTERS_1      = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LETTERS_2      = 2'd3;

    // Reset values.
    localparam logic [PLEN_W-1:0] PLEN_RESET = 6'd1;

    // Pattern held in the register file.
    typedef struct packed {
        logic [PLEN_W-1:0]     pattern_length;
        logic [LETTERS2_W-1:0] letters_2;
        logic [LETTERS1_W-1:0] letters_1;
        logic [LETTERS0_W-1:0] letters_0;
    } t_cfg;

    // One request to a letter map per accepted item.
    typedef struct packed {
        logic                step;    // an item is accepted this cycle
        logic                lookup;  // the letter takes part in the comparison
        logic                clear;   // last letter of the word, forget all codes
        logic [LETTER_W-1:0] letter;
    } t_map_req;

endpackage

`default_nettype wire

[hdl/wpim_ram.sv]
`default_nettype none

module wpim_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hdl/wpim_map.sv]
`default_nettype none

// First-occurrence letter map: seen flags in flops, codes in a small RAM.
// The code of the current letter is valid in the cycle after the request.
module wpim_map #(
    parameter  int ALPHABET_SIZE = wpim_pkg::ALPHABET_SIZE_DEF,
    localparam int AW            = $clog2(ALPHABET_SIZE),
    localparam int CW            = $clog2(ALPHABET_SIZE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wpim_pkg::t_map_req  i_req,
    output logic [CW-1:0]       o_code
);

    localparam int NW = $clog2(ALPHABET_SIZE + 1);

    logic [ALPHABET_SIZE-1:0] r_seen;
    logic [ALPHABET_SIZE-1:0] n_seen;
    logic [NW-1:0]            r_next;
    logic [NW-1:0]            n_next;
    logic                     r_new;
    logic [CW-1:0]            r_new_code;
    logic [AW-1:0]            w_addr;
    logic                     w_new;
    logic [CW-1:0]            w_rdata;

    assign w_addr = i_req.letter[AW-1:0];
    assign w_new  = i_req.lookup && !r_seen[w_addr];

    always_comb begin
        n_seen = r_seen;
        n_next = r_next;
        if (i_req.step) begin
            if (i_req.clear) begin
                n_seen = '0;
                n_next = '0;
            end else if (w_new) begin
                n_seen[w_addr] = 1'b1;
                n_next         = r_next + NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_next <= '0;
        end else begin
            r_seen <= n_seen;
            r_next <= n_next;
        end
    end

    // A new letter takes the next code directly; a known one reads it back.
    always_ff @(posedge i_clk) begin
        if (i_req.step) begin
            r_new      <= w_new;
            r_new_code <= r_next[CW-1:0];
        end
    end

    wpim_ram #(
        .WIDTH (CW),
        .DEPTH (ALPHABET_SIZE)
    ) u_code_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.step && w_new),
        .i_waddr (w_addr),
        .i_wdata (r_next[CW-1:0]),
        .i_re    (i_req.step),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign o_code = r_new ? r_new_code : w_rdata;

endmodule

`default_nettype wire

[hdl/wpim_cfg.sv]
`default_nettype none

// Register file on the APB-style port. Register i sits at byte address 8*i.
module wpim_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wpim_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wpim_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wpim_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output wpim_pkg::t_cfg                      o_cfg
);

    wpim_pkg::t_cfg                     r_cfg;
    logic                               w_wr;
    logic [wpim_pkg::REG_IDX_W-1:0]     w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[wpim_pkg::CFG_ADDR_W-1:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_length <= wpim_pkg::PLEN_RESET;
            r_cfg.letters_0      <= '0;
            r_cfg.letters_1      <= '0;
            r_cfg.letters_2      <= '0;
        end else if (w_wr) begin
            case (w_idx)
                wpim_pkg::REG_PATTERN_LENGTH: begin
                    r_cfg.pattern_length <= pwdata[wpim_pkg::PLEN_W-1:0];
                end
                wpim_pkg::REG_LETTERS_0: begin
                    r_cfg.letters_0 <= pwdata[wpim_pkg::LETTERS0_W-1:0];
                end
                wpim_pkg::REG_LETTERS_1: begin
                    r_cfg.letters_1 <= pwdata[wpim_pkg::LETTERS1_W-1:0];
                end
                wpim_pkg::REG_LETTERS_2: begin
                    r_cfg.letters_2 <= pwdata[wpim_pkg::LETTERS2_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            wpim_pkg::REG_PATTERN_LENGTH: begin
                prdata = wpim_pkg::CFG_DATA_W'(r_cfg.pattern_length);
            end
            wpim_pkg::REG_LETTERS_0: begin
                prdata = wpim_pkg::CFG_DATA_W'(r_cfg.letters_0);
            end
            wpim_pkg::REG_LETTERS_1: begin
                prdata = wpim_pkg::CFG_DATA_W'(r_cfg.letters_1);
            end
            wpim_pkg::REG_LETTERS_2: begin
                prdata = wpim_pkg::CFG_DATA_W'(r_cfg.letters_2);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[hdl/word_pattern_isomorphism_match.sv]
`default_nettype none

// Channel   | Direction | Signals                                  | Carries
// ----------+-----------+------------------------------------------+-------------------------------
// letters   | in        | i_s_tvalid o_s_tready i_s_tdata i_s_tlast | one letter, tlast ends a word
// results   | out       | o_m_tvalid i_m_tready o_m_tdata           | one item per finished word
// registers | in/out    | psel penable pwrite paddr pwdata prdata   | pattern length and letters
//
// One letter is accepted every cycle unless the input stalls. Each letter goes through
// two stages: in the first the seen flags decide whether the letter is new and the
// code RAMs are read or written; in the second the two codes are compared and the
// word's result is formed into the output register. Reset is synchronous and active
// low; it loads the pattern length with one and clears both letter maps. The input
// stalls only when a finished word's result is ready to leave while the output
// register still holds an item not yet taken.
module word_pattern_isomorphism_match #(
    parameter int PATTERN_MAX   = wpim_pkg::PATTERN_MAX_DEF,
    parameter int ALPHABET_SIZE = wpim_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Letter stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,   // [4:0] letter, [7:5] zero
    input  logic                                i_s_tlast,   // end_of_word
    // Result stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [7:0]                          o_m_tdata,   // [0] matched, [1] length_mismatch
    // Register port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wpim_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wpim_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wpim_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int PW = $clog2(PATTERN_MAX + 2);
    localparam int CW = $clog2(ALPHABET_SIZE);
    localparam logic [wpim_pkg::PLEN_W-1:0]   PMAX6  = wpim_pkg::PLEN_W'(PATTERN_MAX);
    localparam logic [wpim_pkg::PLEN_W-1:0]   ALPHA6 = wpim_pkg::PLEN_W'(ALPHABET_SIZE);
    localparam logic [PW-1:0]                 POS_SAT = PW'(PATTERN_MAX + 1);

    wpim_pkg::t_cfg                         w_cfg;
    wpim_pkg::t_map_req                     w_wreq;
    wpim_pkg::t_map_req                     w_preq;
    logic [wpim_pkg::PAT_BITS-1:0]          w_pat_all;

    // Front stage: position tracking and map requests.
    logic                                   w_accept;
    logic                                   w_stall;
    logic [wpim_pkg::LETTER_W-1:0]          w_letter;
    logic [wpim_pkg::LETTER_W-1:0]          w_pat_letter;
    logic [wpim_pkg::PLEN_W-1:0]            w_pos6;
    logic [wpim_pkg::PLEN_W-1:0]            w_pos_next6;
    logic [7:0]                             w_pidx;
    logic                                   w_in_range;
    logic                                   w_cmp;
    logic                                   w_word_ok;
    logic                                   w_pat_ok;
    logic                                   w_force;
    logic                                   w_len_bad;
    logic [PW-1:0]                          r_pos;
    logic [PW-1:0]                          n_pos;
    logic [PW-1:0]                          w_pos_next;

    // Compare stage.
    logic                                   r_s1_valid;
    logic                                   r_s1_last;
    logic                                   r_s1_cmp;
    logic                                   r_s1_word_ok;
    logic                                   r_s1_pat_ok;
    logic                                   r_s1_force;
    logic                                   r_s1_len_bad;
    logic [CW-1:0]                          w_word_code;
    logic [CW-1:0]                          w_pat_code;
    logic                                   w_item_bad;
    logic                                   w_load;
    logic                                   r_mis;

    // Output register.
    logic                                   r_o_valid;
    logic                                   r_o_matched;
    logic                                   r_o_len_bad;

    wpim_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshakes. A finished word in the compare stage waits for the output slot.
    assign w_stall    = r_s1_valid && r_s1_last && r_o_valid && !i_m_tready;
    assign o_s_tready = !w_stall;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_letter  = i_s_tdata[wpim_pkg::LETTER_W-1:0];
    assign w_pat_all = {w_cfg.letters_2, w_cfg.letters_1, w_cfg.letters_0};

    // Pattern letter at the current position; only used while the position is
    // below PATTERN_MAX, so five index bits cover it.
    assign w_pos6       = wpim_pkg::PLEN_W'(r_pos);
    assign w_pidx       = {3'b000, w_pos6[4:0]} * 8'd5;
    assign w_pat_letter = w_pat_all[w_pidx +: wpim_pkg::LETTER_W];

    assign w_in_range = w_pos6 < PMAX6;
    assign w_cmp      = w_in_range && (w_pos6 < w_cfg.pattern_length);
    assign w_word_ok  = {1'b0, w_letter} < ALPHA6;
    assign w_pat_ok   = {1'b0, w_pat_letter} < ALPHA6;
    // Past the longest pattern every letter fails; past the configured length
    // only a letter outside the alphabet does.
    assign w_force    = !w_in_range || (!w_cmp && !w_word_ok);

    assign w_pos_next  = (r_pos == POS_SAT) ? r_pos : r_pos + PW'(1);
    assign w_pos_next6 = wpim_pkg::PLEN_W'(w_pos_next);
    assign w_len_bad   = (w_pos_next6 > PMAX6) || (w_pos_next6 != w_cfg.pattern_length);

    always_comb begin
        n_pos = r_pos;
        if (w_accept) begin
            n_pos = i_s_tlast ? '0 : w_pos_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_comb begin
        w_wreq.step   = w_accept;
        w_wreq.lookup = w_cmp && w_word_ok;
        w_wreq.clear  = i_s_tlast;
        w_wreq.letter = w_letter;
        w_preq.step   = w_accept;
        w_preq.lookup = w_cmp && w_pat_ok;
        w_preq.clear  = i_s_tlast;
        w_preq.letter = w_pat_letter;
    end

    wpim_map #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_word_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_wreq),
        .o_code  (w_word_code)
    );

    wpim_map #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_pat_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_preq),
        .o_code  (w_pat_code)
    );

    // Compare stage registers. The stage only holds still while stalled, and
    // then nothing is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!w_stall) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_last    <= i_s_tlast;
            r_s1_cmp     <= w_cmp;
            r_s1_word_ok <= w_word_ok;
            r_s1_pat_ok  <= w_pat_ok;
            r_s1_force   <= w_force;
            r_s1_len_bad <= w_len_bad;
        end
    end

    assign w_item_bad = r_s1_force
                     || (r_s1_cmp && (!r_s1_word_ok || !r_s1_pat_ok
                                      || (w_word_code != w_pat_code)));
    assign w_load     = r_s1_valid && r_s1_last && !w_stall;

    // Running mismatch of the word in flight; cleared as its last letter leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mis <= 1'b0;
        end else if (r_s1_valid && !w_stall) begin
            r_mis <= r_s1_last ? 1'b0 : (r_mis || w_item_bad);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_matched <= !(r_mis || w_item_bad) && !r_s1_len_bad;
            r_o_len_bad <= r_s1_len_bad;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {6'b000000, r_o_len_bad, r_o_matched};

    // The input side only stalls behind a finished word and a full output slot.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_s1_last && r_o_valid))
        else $error("input stalled without a blocked result");

    // The last letter of a word restarts the position count.
    a_pos_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_s_tlast) |=> (r_pos == '0))
        else $error("position not cleared after end of word");

    // A new result comes only from a word's last letter in the compare stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !$past(r_o_valid)) |-> $past(r_s1_valid && r_s1_last))
        else $error("result without a finished word");

    // A word of the wrong length never matches.
    a_match_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_matched && r_o_len_bad))
        else $error("match reported with a length mismatch");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`default_nettype none

// Letters go in as a stream, and a two-bit verdict comes out for each finished word.
// The sender task feeds letters one item at a time. As each letter is accepted, the
// testbench's own copy of the matcher works out whether that letter ends a word and,
// if so, which verdict the block owes. Verdicts queue up in order. A checker process
// takes every item leaving the result port and compares it with the oldest verdict.
// The pattern registers are written only while no letter is in flight.
module tb_top;
    import wpim_pkg::*;

    localparam int PMAX  = PATTERN_MAX_DEF;
    localparam int ALPHA = ALPHABET_SIZE_DEF;
    localparam int RANDOM_LETTERS = 640;
    localparam int TAIL_LETTERS   = 150;   // final stretch run without idle cycles

    localparam logic [REG_IDX_W-1:0] ALL_REGS [4] = '{REG_PATTERN_LENGTH, REG_LETTERS_0,
                                                      REG_LETTERS_1, REG_LETTERS_2};

    typedef logic [LETTER_W-1:0] t_letter;

    // Layout of o_m_tdata[1:0]: matched in bit 0, length_mismatch in bit 1.
    typedef struct packed {
        logic length_mismatch;
        logic matched;
    } t_verdict;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata  = '0;    // [4:0] letter, [7:5] zero
    logic                  i_s_tlast  = 1'b0;  // end_of_word
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [7:0]            o_m_tdata;          // [0] matched, [1] length_mismatch
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr      = '0;
    logic [CFG_DATA_W-1:0] pwdata     = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    word_pattern_isomorphism_match u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Matcher copy: pattern shadow, both letter maps and the per-word progress.
    // ------------------------------------------------------------------------
    t_cfg          pat_cfg;
    logic [4:0]    w_code_map [ALPHA];
    bit            w_known    [ALPHA];
    logic [4:0]    p_code_map [ALPHA];
    bit            p_known    [ALPHA];
    logic [5:0]    w_code_next;
    logic [5:0]    p_code_next;
    logic [5:0]    letter_pos;
    bit            word_failed;

    t_verdict      verdicts_q [$];

    // Run bookkeeping.
    int            fail_count    = 0;
    int            letters_in    = 0;
    int            words_out     = 0;
    int            matches_out   = 0;
    int            pattern_loads = 0;

    // Idle control shared by the tests, the sender and the receiver.
    bit            src_idle_on   = 1'b1;
    bit            sink_idle_on  = 1'b1;
    int            sink_hold     = 0;

    function automatic void forget_word();
        for (int i = 0; i < ALPHA; i++) begin
            w_code_map[i] = '0;
            w_known[i]    = 1'b0;
            p_code_map[i] = '0;
            p_known[i]    = 1'b0;
        end
        w_code_next = '0;
        p_code_next = '0;
        letter_pos  = '0;
        word_failed = 1'b0;
    endfunction

    // Advances the matcher copy by one letter. Returns 1 when the letter closes a word,
    // with the verdict the block must produce for it.
    function automatic bit classify_letter(input t_letter letter, input logic eow,
                                           output t_verdict v);
        logic [PAT_BITS-1:0] pat_bits;
        t_letter             pl;
        logic [4:0]          wc;
        logic [4:0]          pc;
        bit                  len_bad;

        pat_bits = {pat_cfg.letters_2, pat_cfg.letters_1, pat_cfg.letters_0};
        wc = '0;
        pc = '0;
        v  = '0;
        if (letter_pos >= PMAX) begin
            // Past the longest pattern the block holds, every letter is a failure.
            word_failed = 1'b1;
        end else if (letter_pos < pat_cfg.pattern_length) begin
            pl = pat_bits[letter_pos * 5 +: 5];
            if (letter < ALPHA) begin
                if (!w_known[letter]) begin
                    w_known[letter]    = 1'b1;
                    w_code_map[letter] = w_code_next[4:0];
                    w_code_next++;
                end
                wc = w_code_map[letter];
            end
            if (pl < ALPHA) begin
                if (!p_known[pl]) begin
                    p_known[pl]    = 1'b1;
                    p_code_map[pl] = p_code_next[4:0];
                    p_code_next++;
                end
                pc = p_code_map[pl];
            end
            if (letter >= ALPHA || pl >= ALPHA || wc != pc)
                word_failed = 1'b1;
        end else if (letter >= ALPHA) begin
            // Beyond the pattern only letters outside the alphabet matter here;
            // the length check catches the rest.
            word_failed = 1'b1;
        end

        if (letter_pos < PMAX + 1)
            letter_pos++;

        if (!eow)
            return 1'b0;

        len_bad = (letter_pos > PMAX) || (letter_pos != pat_cfg.pattern_length);
        v.matched         = !word_failed && !len_bad;
        v.length_mismatch = len_bad;
        forget_word();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Register port. Setup cycle, then access cycle; the transfer completes at the
    // rising edge where penable and pready are both high.
    // ------------------------------------------------------------------------
    task automatic reg_access(input logic is_write, input logic [REG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 3'b000};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        logic [CFG_DATA_W-1:0] unused;

        reg_access(1'b1, idx, value, unused);
        // The shadow keeps only the bits the register actually holds.
        case (idx)
            REG_PATTERN_LENGTH: pat_cfg.pattern_length = value[PLEN_W-1:0];
            REG_LETTERS_0:      pat_cfg.letters_0      = value[LETTERS0_W-1:0];
            REG_LETTERS_1:      pat_cfg.letters_1      = value[LETTERS1_W-1:0];
            REG_LETTERS_2:      pat_cfg.letters_2      = value[LETTERS2_W-1:0];
            default: ;
        endcase
    endtask

    task automatic check_reg(input logic [REG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] got;
        logic [CFG_DATA_W-1:0] want;

        reg_access(1'b0, idx, '0, got);
        case (idx)
            REG_PATTERN_LENGTH: want = CFG_DATA_W'(pat_cfg.pattern_length);
            REG_LETTERS_0:      want = CFG_DATA_W'(pat_cfg.letters_0);
            REG_LETTERS_1:      want = CFG_DATA_W'(pat_cfg.letters_1);
            default:            want = CFG_DATA_W'(pat_cfg.letters_2);
        endcase
        if (got !== want) begin
            $error("register %0d readback: expected %h, actual %h", idx, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Letter stream.
    // ------------------------------------------------------------------------

    // Drops tvalid, waits until every owed verdict has left the block, and then lets
    // anything still in the two-stage pipeline drain out.
    task automatic settle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (verdicts_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Offers one letter and holds it until the block takes it. tvalid stays high after
    // the handshake so that the next letter can follow on the very next cycle.
    task automatic send_letter(input t_letter letter, input logic eow);
        t_verdict v;

        @(negedge i_clk);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(8 - LETTER_W){1'b0}}, letter};
        i_s_tlast  <= eow;
        do @(posedge i_clk); while (!o_s_tready);
        letters_in++;
        if (classify_letter(letter, eow, v))
            verdicts_q = {verdicts_q, v};
    endtask

    task automatic send_word(input t_letter w [$]);
        foreach (w[i])
            send_letter(w[i], i == w.size() - 1);
    endtask

    // Writes all four pattern registers. Letters past the given list get random
    // content, which the block must ignore.
    task automatic load_pattern(input logic [PLEN_W-1:0] plen, input t_letter letters [$]);
        logic [PAT_BITS-1:0] bits;

        settle();
        for (int i = 0; i < PMAX; i++)
            bits[i * 5 +: 5] = (i < letters.size()) ? letters[i] : t_letter'($urandom);
        write_reg(REG_LETTERS_0, CFG_DATA_W'(bits[LETTERS0_W-1:0]));
        write_reg(REG_LETTERS_1, CFG_DATA_W'(bits[LETTERS0_W +: LETTERS1_W]));
        write_reg(REG_LETTERS_2, CFG_DATA_W'(bits[LETTERS0_W + LETTERS1_W +: LETTERS2_W]));
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(plen));
        pattern_loads++;
    endtask

    // Pattern built from a handful of letters so that repeats are common, with the
    // odd letter from outside the alphabet.
    task automatic load_random_pattern(input int plen);
        t_letter pool [6];
        t_letter letters [$];
        int      k;

        k = $urandom_range(1, 6);
        for (int i = 0; i < 6; i++)
            pool[i] = t_letter'($urandom_range(0, ALPHA - 1));
        for (int i = 0; i < PMAX; i++) begin
            if ($urandom_range(0, 39) == 0)
                letters = {letters, t_letter'($urandom_range(ALPHA, 31))};
            else
                letters = {letters, pool[$urandom_range(0, k - 1)]};
        end
        load_pattern(PLEN_W'(plen), letters);
    endtask

    // Word that follows the current pattern through a random one-to-one renaming of
    // letters, so it matches unless the pattern itself is unmatchable.
    task automatic build_fitting_word(output t_letter w [$]);
        logic [PAT_BITS-1:0] bits;
        t_letter             perm [ALPHA];
        t_letter             tmp;
        t_letter             pl;
        int                  j;
        int                  n;

        bits = {pat_cfg.letters_2, pat_cfg.letters_1, pat_cfg.letters_0};
        for (int i = 0; i < ALPHA; i++)
            perm[i] = t_letter'(i);
        for (int i = ALPHA - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        if (pat_cfg.pattern_length >= 1 && pat_cfg.pattern_length <= PMAX)
            n = int'(pat_cfg.pattern_length);
        else
            n = $urandom_range(1, 8);
        w = {};
        for (int i = 0; i < n; i++) begin
            pl = bits[i * 5 +: 5];
            w = {w, (pl < ALPHA) ? perm[pl] : t_letter'($urandom_range(0, ALPHA - 1))};
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver. A long hold requested by a test takes priority; otherwise tready
    // drops in random bursts while idling is enabled.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int burst_left;

        burst_left = 0;
        forever begin
            @(negedge i_clk);
            if (sink_hold != 0) begin
                sink_hold--;
                i_m_tready <= 1'b0;
            end else if (burst_left != 0) begin
                burst_left--;
                i_m_tready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(0, 10);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Every item leaving the result port must match the oldest owed verdict.
    always @(posedge i_clk) begin : result_check
        t_verdict got;
        t_verdict want;

        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[1:0];
            words_out++;
            if (got.matched === 1'b1)
                matches_out++;
            if (verdicts_q.size() == 0) begin
                $error("result item %b arrived with no word outstanding", got);
                fail_count++;
            end else begin
                want = verdicts_q.pop_front();
                if (got.matched !== want.matched) begin
                    $error("matched: expected %b, actual %b", want.matched, got.matched);
                    fail_count++;
                end
                if (got.length_mismatch !== want.length_mismatch) begin
                    $error("length_mismatch: expected %b, actual %b",
                           want.length_mismatch, got.length_mismatch);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Straight after reset the pattern is the single letter a, so any one-letter word
    // matches and anything longer fails on length.
    task automatic test_reset_pattern();
        send_word('{t_letter'(16)});
        send_word('{t_letter'(3), t_letter'(3)});
    endtask

    // Reset values, all-ones writes (only the implemented bits stick), random data and zeros.
    task automatic test_register_access();
        settle();
        foreach (ALL_REGS[i])
            check_reg(ALL_REGS[i]);
        foreach (ALL_REGS[i]) begin
            write_reg(ALL_REGS[i], '1);
            check_reg(ALL_REGS[i]);
        end
        foreach (ALL_REGS[i]) begin
            write_reg(ALL_REGS[i], {$urandom, $urandom});
            check_reg(ALL_REGS[i]);
        end
        foreach (ALL_REGS[i]) begin
            write_reg(ALL_REGS[i], '0);
            check_reg(ALL_REGS[i]);
        end
    endtask

    // Hand-picked words against the pattern abba and a few unmatchable patterns.
    task automatic test_directed_words();
        load_pattern(PLEN_W'(4), '{t_letter'(0), t_letter'(1), t_letter'(1), t_letter'(0)});
        send_word('{t_letter'(23), t_letter'(25), t_letter'(25), t_letter'(23)});
        // Same letters in the wrong shape.
        send_word('{t_letter'(23), t_letter'(25), t_letter'(23), t_letter'(25)});
        // One letter short.
        send_word('{t_letter'(23), t_letter'(24), t_letter'(24)});
        // Right shape, then an extra letter from outside the alphabet.
        send_word('{t_letter'(0), t_letter'(1), t_letter'(1), t_letter'(0), t_letter'(31)});
        // Letters outside the alphabet at compared positions.
        send_word('{t_letter'(0), t_letter'(31), t_letter'(31), t_letter'(0)});

        // A zero length pattern cannot be met.
        load_pattern(PLEN_W'(0), '{t_letter'(0)});
        send_word('{t_letter'(0)});
        // Nor can one longer than the block holds.
        load_pattern(PLEN_W'(63), '{t_letter'(0)});
        send_word('{t_letter'(0)});
        // Pattern letter outside the alphabet.
        load_pattern(PLEN_W'(1), '{t_letter'(31)});
        send_word('{t_letter'(7)});
    endtask

    // Full-length pattern and words that run past the longest pattern.
    task automatic test_overlong_words();
        t_letter w [$];

        load_random_pattern(PMAX);
        build_fitting_word(w);
        send_word(w);
        w = {w, t_letter'($urandom_range(0, ALPHA - 1))};
        send_word(w);
        repeat (7) w = {w, t_letter'($urandom_range(0, ALPHA - 1))};
        send_word(w);
        load_random_pattern(5);
        build_fitting_word(w);
        repeat (31) w = {w, t_letter'($urandom_range(0, ALPHA - 1))};
        send_word(w);
    endtask

    // The receiver holds off for a long time while short words keep coming, so the
    // output register fills and the block must stall its input.
    task automatic test_output_stall();
        t_letter w [$];

        load_random_pattern(2);
        src_idle_on = 1'b0;
        @(posedge i_clk);
        sink_hold = 200;
        repeat (30) begin
            w = {};
            repeat ($urandom_range(1, 3))
                w = {w, t_letter'($urandom_range(0, ALPHA - 1))};
            send_word(w);
        end
        src_idle_on = 1'b1;
    endtask

    // Short bursts of words, each followed by a full drain of the block.
    task automatic test_sender_pause();
        t_letter w [$];

        load_random_pattern(3);
        repeat (5) begin
            repeat ($urandom_range(1, 4)) begin
                build_fitting_word(w);
                send_word(w);
            end
            settle();
        end
    endtask

    // Mostly words that fit the current pattern, some with one letter spoiled, some
    // with the length off, plus pure noise and the occasional overlong word.
    task automatic test_random_words();
        t_letter w [$];
        int      start;
        int      r;
        int      plen;
        int      n;

        start = letters_in;
        while (letters_in - start < RANDOM_LETTERS) begin
            if (letters_in == start || $urandom_range(0, 9) == 0) begin
                r = $urandom_range(0, 99);
                if (r < 3)       plen = 0;
                else if (r < 6)  plen = $urandom_range(PMAX + 1, 63);
                else if (r < 14) plen = PMAX;
                else if (r < 24) plen = $urandom_range(9, PMAX - 1);
                else             plen = $urandom_range(1, 8);
                load_random_pattern(plen);
            end
            if (letters_in - start > RANDOM_LETTERS - TAIL_LETTERS) begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end

            r = $urandom_range(0, 19);
            if (r < 13) begin
                build_fitting_word(w);
                if (r < 4)
                    w[$urandom_range(0, w.size() - 1)] = t_letter'($urandom_range(0, 31));
            end else if (r < 16) begin
                build_fitting_word(w);
                if (w.size() > 1 && $urandom_range(0, 1) == 0) begin
                    n = $urandom_range(1, (w.size() > 3) ? 3 : w.size() - 1);
                    repeat (n) void'(w.pop_back());
                end else begin
                    repeat ($urandom_range(1, 3))
                        w = {w, t_letter'($urandom_range(0, 31))};
                end
            end else begin
                w = {};
                n = (r < 19) ? $urandom_range(1, 12) : $urandom_range(PMAX + 1, PMAX + 8);
                repeat (n) begin
                    if ($urandom_range(0, 7) == 0)
                        w = {w, t_letter'($urandom_range(ALPHA, 31))};
                    else
                        w = {w, t_letter'($urandom_range(0, ALPHA - 1))};
                end
            end
            send_word(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        pat_cfg = '0;
        pat_cfg.pattern_length = PLEN_RESET;
        forget_word();

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_pattern();
        test_register_access();
        test_directed_words();
        test_overlong_words();
        test_output_stall();
        test_sender_pause();
        test_random_words();

        settle();
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d letters, %0d words checked (%0d matching), %0d patterns.",
                 letters_in, words_out, matches_out, pattern_loads);
        $display("Included register readback, overlong words, a long output stall.");
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/wpim_pkg.sv
hdl/wpim_ram.sv
hdl/wpim_map.sv
hdl/wpim_cfg.sv
hdl/word_pattern_isomorphism_match.sv
sim/tb_top.sv
